// ----- hw/rtl/rf_pulse_width_code_receiver_macros.svh -----
// assertion macros for the pulse width code receiver checker
// no dependencies; included by the checker file only
`ifndef RF_PULSE_WIDTH_CODE_RECEIVER_MACROS_SVH
`define RF_PULSE_WIDTH_CODE_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RFPWC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RFPWC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rfpwc_pkg.sv -----
// shared types and constants of the pulse width code receiver
// no dependencies; imported by every module of the block
package rfpwc_pkg;

    localparam int RING_DEPTH   = 64;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int ENTRY_W      = 13;
    localparam int CODE_BITS    = 12;
    localparam int POPS_PER_BIT = 4;
    localparam int WALK_POPS    = CODE_BITS * POPS_PER_BIT;
    localparam int POP_CNT_W    = $clog2(WALK_POPS);
    localparam int QUEUE_DEPTH  = 2;

    localparam int INTERVAL_W   = 16;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;
    localparam int UNIT_W       = 10;
    localparam int TOL_W        = 9;
    localparam int GAP_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP   = 2'd2;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 10'd300;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 9'd75;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 13'd5000;

    typedef struct packed {
        logic [UNIT_W-1:0] pulse_unit_us;
        logic [TOL_W-1:0]  pulse_tolerance_us;
        logic [GAP_W-1:0]  sync_gap_us;
    } cfg_t;

    typedef struct packed {
        logic               frame_end;
        logic [ENTRY_W-1:0] interval;
    } edge_cmd_t;

endpackage

// ----- hw/rtl/rfpwc_front.sv -----
// front end: configuration registers and edge classification
// depends on rfpwc_pkg
module rfpwc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rfpwc_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] edge_interval_us
    input  logic                                cfg_wr_en,
    input  logic [rfpwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rfpwc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output rfpwc_pkg::cfg_t                     cfg,
    output logic                                push_valid,
    input  logic                                push_ready,
    output rfpwc_pkg::edge_cmd_t                push_cmd
);
    import rfpwc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [INTERVAL_W-1:0] interval;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PULSE_UNIT: cfg_next.pulse_unit_us      = cfg_wdata[UNIT_W-1:0];
                CFG_PULSE_TOL:  cfg_next.pulse_tolerance_us = cfg_wdata[TOL_W-1:0];
                CFG_SYNC_GAP:   cfg_next.sync_gap_us        = cfg_wdata[GAP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_unit_us      <= UNIT_RESET;
            cfg_reg.pulse_tolerance_us <= TOL_RESET;
            cfg_reg.sync_gap_us        <= GAP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // intervals above the sync gap close a frame
    assign interval           = s_tdata[INTERVAL_W-1:0];
    assign push_cmd.frame_end = interval > {{(INTERVAL_W-GAP_W){1'b0}}, cfg_reg.sync_gap_us};
    assign push_cmd.interval  = interval[ENTRY_W-1:0];
    assign push_valid         = s_tvalid;
    assign s_tready           = push_ready;
    assign cfg                = cfg_reg;

endmodule

// ----- hw/rtl/rfpwc_queue.sv -----
// short command queue between front and back end
// depends on rfpwc_pkg
module rfpwc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rfpwc_pkg::edge_cmd_t  push_cmd,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output rfpwc_pkg::edge_cmd_t  pop_cmd
);
    import rfpwc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    edge_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/rfpwc_back.sv -----
// back end: interval ring, frame walk and result register
// depends on rfpwc_pkg
module rfpwc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rfpwc_pkg::cfg_t                   cfg,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  rfpwc_pkg::edge_cmd_t              cmd,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rfpwc_pkg::M_TDATA_W-1:0]   m_tdata,   // [11:0] received_code
    output logic                              m_tuser    // [0] code_ok
);
    import rfpwc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } back_state_t;

    localparam logic [1:0] PHASE_SKIP   = 2'd0;
    localparam logic [1:0] PHASE_THIRD  = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;
    localparam logic [1:0] PHASE_FIRST  = 2'd3;

    back_state_t state_reg, state_next;

    logic [ENTRY_W-1:0]    ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] ring_valid_reg;

    logic [RING_AW-1:0]    pos_reg, pos_next;
    logic [RING_AW-1:0]    rd_addr_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;
    logic [RING_AW-1:0]    mark_addr_reg, mark_addr_next;
    logic [POP_CNT_W-1:0]  pop_cnt_reg, pop_cnt_next;
    logic [CODE_BITS-1:0]  code_reg, code_next;
    logic                  third_short_reg, third_short_next;
    logic                  third_long_reg, third_long_next;
    logic                  second_long_reg, second_long_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CODE_BITS-1:0]  m_code_reg, m_code_next;
    logic                  m_ok_reg, m_ok_next;

    logic [UNIT_W-1:0]     short_lo_reg;
    logic [UNIT_W:0]       short_hi_reg;
    logic [UNIT_W+1:0]     long_lo_reg;
    logic [UNIT_W+2:0]     long_hi_reg;
    logic [UNIT_W-1:0]     lo_bound;
    logic [UNIT_W:0]       hi_bound;

    logic                  mem_we;
    logic [RING_AW-1:0]    mem_waddr;
    logic [RING_AW-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    logic [ENTRY_W-1:0]    entry;
    logic                  e_short, e_long;
    logic                  bit_fail;

    function automatic logic [RING_AW-1:0] ring_dec(input logic [RING_AW-1:0] a);
        if (a == '0) begin
            ring_dec = RING_AW'(RING_DEPTH - 1);
        end else begin
            ring_dec = a - 1'b1;
        end
    endfunction

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] a);
        if (a == RING_AW'(RING_DEPTH - 1)) begin
            ring_inc = '0;
        end else begin
            ring_inc = a + 1'b1;
        end
    endfunction

    // window bounds, lower ones clamped at zero
    assign lo_bound = (cfg.pulse_unit_us > {1'b0, cfg.pulse_tolerance_us})
                    ? cfg.pulse_unit_us - {1'b0, cfg.pulse_tolerance_us} : '0;
    assign hi_bound = {1'b0, cfg.pulse_unit_us} + {2'b00, cfg.pulse_tolerance_us};

    always_ff @(posedge aclk) begin
        short_lo_reg <= lo_bound;
        short_hi_reg <= hi_bound;
        long_lo_reg  <= {2'b00, lo_bound} + {1'b0, lo_bound, 1'b0};
        long_hi_reg  <= {2'b00, hi_bound} + {1'b0, hi_bound, 1'b0};
    end

    // unwritten entries read as zero
    assign entry   = rd_valid_reg ? rd_data_reg : '0;
    assign e_short = (entry >= {{(ENTRY_W-UNIT_W){1'b0}}, short_lo_reg})
                  && (entry <= {{(ENTRY_W-UNIT_W-1){1'b0}}, short_hi_reg});
    assign e_long  = (entry >= {{(ENTRY_W-UNIT_W-2){1'b0}}, long_lo_reg})
                  && (entry <= ENTRY_W'(long_hi_reg));
    assign bit_fail = !(e_short && second_long_reg) || !(third_short_reg || third_long_reg);

    always_comb begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        mark_addr_next   = mark_addr_reg;
        pop_cnt_next     = pop_cnt_reg;
        code_next        = code_reg;
        third_short_next = third_short_reg;
        third_long_next  = third_long_reg;
        second_long_next = second_long_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_code_next      = m_code_reg;
        m_ok_next        = m_ok_reg;
        cmd_ready        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = pos_reg;
        mem_wdata        = '0;
        mem_raddr        = ring_dec(rd_addr_reg);

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                mem_raddr = ring_dec(pos_reg);
                if (cmd_valid) begin
                    if (cmd.frame_end) begin
                        pos_next   = ring_dec(pos_reg);
                        state_next = ST_CHECK;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = cmd.interval;
                        pos_next  = ring_inc(pos_reg);
                    end
                end
            end
            ST_CHECK: begin
                code_next    = '0;
                pop_cnt_next = '0;
                state_next   = e_short ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                pop_cnt_next = pop_cnt_reg + 1'b1;
                case (pop_cnt_reg[1:0])
                    PHASE_SKIP: begin
                    end
                    PHASE_THIRD: begin
                        third_short_next = e_short;
                        third_long_next  = e_long;
                    end
                    PHASE_SECOND: begin
                        second_long_next = e_long;
                    end
                    PHASE_FIRST: begin
                        if (bit_fail) begin
                            code_next      = '0;
                            mark_addr_next = rd_addr_reg;
                            state_next     = ST_FINISH;
                        end else begin
                            code_next = {third_short_reg, code_reg[CODE_BITS-1:1]};
                            if (pop_cnt_reg == POP_CNT_W'(WALK_POPS - 1)) begin
                                mark_addr_next = rd_addr_reg;
                                state_next     = ST_FINISH;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    mem_we       = 1'b1;
                    mem_waddr    = mark_addr_reg;
                    mem_wdata    = '0;
                    pos_next     = ring_inc(mark_addr_reg);
                    m_valid_next = 1'b1;
                    m_code_next  = code_reg;
                    m_ok_next    = |code_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            m_valid_reg    <= 1'b0;
            ring_valid_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (mem_we) begin
                ring_valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mark_addr_reg   <= mark_addr_next;
        pop_cnt_reg     <= pop_cnt_next;
        code_reg        <= code_next;
        third_short_reg <= third_short_next;
        third_long_reg  <= third_long_next;
        second_long_reg <= second_long_next;
        m_code_reg      <= m_code_next;
        m_ok_reg        <= m_ok_next;
        rd_addr_reg     <= mem_raddr;
        rd_valid_reg    <= ring_valid_reg[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[mem_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CODE_BITS){1'b0}}, m_code_reg};
    assign m_tuser  = m_ok_reg;

endmodule

// ----- hw/rtl/rf_pulse_width_code_receiver.sv -----
// top level of the pulse width code receiver
// depends on rfpwc_pkg, rfpwc_front, rfpwc_queue and rfpwc_back
//
// Takes edge-to-edge intervals in microseconds and decodes 12-bit remote switch
// frames. An interval up to the sync gap is stored in a 64-entry ring; an interval
// above it steps the ring back one entry and, when that entry is a short pulse,
// walks 48 earlier entries, four per bit, at one ring read per cycle. A two-request
// queue lets edges keep arriving during a walk. One result per decoded frame: the
// code in m_tdata, code_ok in m_tuser, which is low for an invalid frame or a zero
// code. The ring reads as zero after reset straight away; there is no clearing
// pass. Configure only while idle.
module rf_pulse_width_code_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rfpwc_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] edge_interval_us
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rfpwc_pkg::M_TDATA_W-1:0]   m_tdata,   // [11:0] received_code
    output logic                              m_tuser,   // [0] code_ok
    input  logic                              cfg_wr_en,
    input  logic [rfpwc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfpwc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rfpwc_pkg::*;

    cfg_t      cfg;
    edge_cmd_t push_cmd;
    edge_cmd_t pop_cmd;
    logic      push_valid, push_ready;
    logic      pop_valid, pop_ready;

    rfpwc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    rfpwc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    rfpwc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- hw/rtl/rfpwc_checker.sv -----
// port-level checker for the pulse width code receiver, bound to the top level
// depends on rfpwc_pkg and rf_pulse_width_code_receiver_macros.svh
`include "rf_pulse_width_code_receiver_macros.svh"

module rfpwc_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rfpwc_pkg::M_TDATA_W-1:0]   m_tdata,   // [11:0] received_code
    input  logic                              m_tuser    // [0] code_ok
);
    import rfpwc_pkg::*;

    `RFPWC_ASSERT_NXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `RFPWC_ASSERT_NXT(a_result_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `RFPWC_ASSERT_IMP(a_ok_matches_code, aclk, aresetn, m_tvalid, m_tuser == (m_tdata[CODE_BITS-1:0] != '0), "code_ok disagrees with code")
    `RFPWC_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:CODE_BITS] == '0, "padding bits set")

endmodule

bind rf_pulse_width_code_receiver rfpwc_checker u_rfpwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/rf_pulse_width_code_receiver_test.sv -----
`timescale 1ns / 100ps
// self-checking bench for the pulse width code receiver: random and directed interval
// streams, an in-bench decoder of the ring and frame walk, results checked in order
// depends on rfpwc_pkg and rf_pulse_width_code_receiver
module rf_pulse_width_code_receiver_test;
    import rfpwc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 3000;
    localparam int RUN_LIMIT     = 1000000;

    typedef struct {
        logic [CODE_BITS-1:0] code;
        logic                 ok;
    } code_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // decoder copy of the block state and registers
    logic [ENTRY_W-1:0] ring_store [RING_DEPTH];
    logic [RING_AW-1:0] ring_ptr = '0;
    int unsigned        cfg_unit = 32'(UNIT_RESET);
    int unsigned        cfg_tol  = 32'(TOL_RESET);
    int unsigned        cfg_gap  = 32'(GAP_RESET);

    logic [INTERVAL_W-1:0] interval_queue [$];
    code_result_t          expected_codes [$];
    int                    intervals_queued = 0;
    int                    intervals_taken = 0;
    int                    codes_seen = 0;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;
    bit                    s_took = 1'b0;
    int                    burst_left = 1;
    int                    gap_left = 0;
    bit                    hold_armed = 1'b0;
    bit                    hold_done = 1'b0;
    int                    hold_left = 0;
    int                    ready_mode = 0;
    int                    ready_run = 0;
    logic [CODE_BITS-1:0]  taken_code;
    code_result_t          want;

    rf_pulse_width_code_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        foreach (ring_store[i]) ring_store[i] = '0;
    end

    function automatic bit fits_window(logic [ENTRY_W-1:0] v, int unsigned mult);
        int unsigned lo;
        lo = (cfg_unit > cfg_tol) ? cfg_unit - cfg_tol : 0;
        return 32'(v) >= mult * lo && 32'(v) <= mult * (cfg_unit + cfg_tol);
    endfunction

    function automatic logic [RING_AW-1:0] ring_prev(logic [RING_AW-1:0] p);
        return (p == '0) ? RING_AW'(RING_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [RING_AW-1:0] ring_next(logic [RING_AW-1:0] p);
        return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ENTRY_W-1:0] ring_back();
        ring_ptr = ring_prev(ring_ptr);
        return ring_store[ring_ptr];
    endfunction

    // returns 1 when the interval closes a frame that gets decoded
    function automatic bit decode_interval(input logic [INTERVAL_W-1:0] interval,
                                           output logic [CODE_BITS-1:0] code);
        logic [ENTRY_W-1:0] third, second, first;
        code = '0;
        if (32'(interval) <= cfg_gap) begin
            ring_store[ring_ptr] = interval[ENTRY_W-1:0];
            ring_ptr = ring_next(ring_ptr);
            return 1'b0;
        end
        if (!fits_window(ring_back(), 1))
            return 1'b0;
        for (int b = 0; b < CODE_BITS; b++) begin
            void'(ring_back());
            third = ring_back();
            second = ring_back();
            first = ring_back();
            code = code >> 1;
            if (!(fits_window(first, 1) && fits_window(second, 3))) begin
                code = '0;
                break;
            end
            if (fits_window(third, 1)) begin
                code[CODE_BITS-1] = 1'b1;
            end else if (!fits_window(third, 3)) begin
                code = '0;
                break;
            end
        end
        ring_store[ring_ptr] = '0;
        ring_ptr = ring_next(ring_ptr);
        return 1'b1;
    endfunction

    // input side: bursts with gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (interval_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= interval_queue.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(30, 1);
                    gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: own stall pattern plus one long hold
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (ready_run == 0) begin
                    ready_mode = $urandom_range(2);
                    ready_run = (ready_mode == 1) ? $urandom_range(8, 1) : $urandom_range(40, 1);
                end
                ready_run--;
                m_tready <= (ready_mode == 0) || (ready_mode == 2 && $urandom_range(1) == 1);
            end
        end
    end

    always @(posedge aclk) begin
        s_took = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                s_took = 1'b1;
                intervals_taken++;
                if (decode_interval(s_tdata[INTERVAL_W-1:0], taken_code))
                    expected_codes.push_back('{code: taken_code, ok: taken_code != '0});
            end
            if (m_tvalid && m_tready) begin
                codes_seen++;
                if (expected_codes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, code %03h ok %b",
                             $time, m_tdata[CODE_BITS-1:0], m_tuser);
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata[CODE_BITS-1:0] !== want.code) begin
                        mismatch_count++;
                        $display("%0t: received_code expected %03h got %03h",
                                 $time, want.code, m_tdata[CODE_BITS-1:0]);
                    end
                    if (m_tuser !== want.ok) begin
                        mismatch_count++;
                        $display("%0t: code_ok expected %b got %b", $time, want.ok, m_tuser);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic offer(logic [INTERVAL_W-1:0] v);
        interval_queue.push_back(v);
        intervals_queued++;
    endtask

    function automatic logic [INTERVAL_W-1:0] pulse_of(int unsigned mult);
        int unsigned lo, hi;
        lo = mult * ((cfg_unit > cfg_tol) ? cfg_unit - cfg_tol : 0);
        hi = mult * (cfg_unit + cfg_tol);
        if (hi > cfg_gap)
            hi = cfg_gap;
        if (lo > hi)
            return INTERVAL_W'(lo);
        return INTERVAL_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [INTERVAL_W-1:0] gap_interval();
        if ($urandom_range(3) == 0)
            return 16'hFFFF;
        return INTERVAL_W'($urandom_range(cfg_gap + 1 + $urandom_range(3000), cfg_gap + 1));
    endfunction

    function automatic logic [INTERVAL_W-1:0] noise_interval();
        case ($urandom_range(6))
            0: return INTERVAL_W'($urandom_range(16'hFFFF));
            1: return pulse_of(1);
            2: return pulse_of(3);
            3: return INTERVAL_W'(cfg_gap);
            4: return INTERVAL_W'($urandom_range(cfg_gap));
            5: return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            default: return gap_interval();
        endcase
    endfunction

    // twelve bits of short, long, data, filler, then the sync pulse and gap
    task automatic queue_frame(logic [CODE_BITS-1:0] code, bit corrupt);
        logic [INTERVAL_W-1:0] seq [$];
        for (int b = CODE_BITS - 1; b >= 0; b--) begin
            seq.push_back(pulse_of(1));
            seq.push_back(pulse_of(3));
            seq.push_back(code[b] ? pulse_of(1) : pulse_of(3));
            seq.push_back(code[b] ? pulse_of(3) : pulse_of(1));
        end
        seq.push_back(pulse_of(1));
        if (corrupt)
            seq[$urandom_range(seq.size() - 1)] = noise_interval();
        seq.push_back(gap_interval());
        foreach (seq[i]) offer(seq[i]);
    endtask

    task automatic queue_random_intervals(int item_goal, int end_goal);
        int items, ends, pick, n;
        logic [CODE_BITS-1:0] code;
        items = 0;
        ends = 0;
        while (items < item_goal || ends < end_goal) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
                code = CODE_BITS'($urandom_range(12'hFFF));
                case ($urandom_range(9))
                    0: code = '0;
                    1: code = '1;
                    2: code = 12'h800;
                    3: code = 12'h001;
                    default: ;
                endcase
                queue_frame(code, $urandom_range(3) == 0);
                items += 4 * CODE_BITS + 2;
                ends++;
            end else if (pick < 8) begin
                n = $urandom_range(10, 1);
                repeat (n) offer(noise_interval());
                items += n;
            end else begin
                offer(pulse_of(1));
                offer(gap_interval());
                offer(gap_interval());
                items += 3;
                ends += 2;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_PULSE_UNIT: cfg_unit = 32'(value[UNIT_W-1:0]);
            CFG_PULSE_TOL:  cfg_tol = 32'(value[TOL_W-1:0]);
            CFG_SYNC_GAP:   cfg_gap = 32'(value[GAP_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(int unsigned unit, int unsigned tol, int unsigned gap);
        write_reg(CFG_PULSE_UNIT, CFG_DATA_W'(unit));
        write_reg(CFG_PULSE_TOL, CFG_DATA_W'(tol));
        write_reg(CFG_SYNC_GAP, CFG_DATA_W'(gap));
    endtask

    task automatic wait_idle();
        while (intervals_taken != intervals_queued || expected_codes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [INTERVAL_W-1:0] opening [$] = '{
            16'd0, 16'd375, 16'hFFFF, 16'd5000, 16'd5001, 16'd224, 16'd376, 16'd674,
            16'd1126, 16'd225, 16'd675, 16'd1125, 16'd300, 16'd5001, 16'd5001,
            16'h1555, 16'hAAAA
        };
        int unsigned unit, tol;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: window edges, gap boundary, decode over an empty ring
        foreach (opening[i]) offer(opening[i]);
        hold_armed = 1'b1;
        queue_random_intervals(150, 5);
        wait_idle();

        // exact windows, widest gap
        set_config(1000, 0, 8191);
        queue_random_intervals(150, 5);
        wait_idle();

        // tolerance above unit, narrowest gap
        set_config(100, 500, 1000);
        queue_random_intervals(150, 5);
        wait_idle();

        // upper bits beyond the register widths, spare index
        write_reg(CFG_PULSE_UNIT, 13'h15F4);
        write_reg(CFG_PULSE_TOL, 13'h1E64);
        write_reg(CFG_SYNC_GAP, 13'd3000);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(13'h1FFF)));
        queue_random_intervals(150, 5);
        wait_idle();

        unit = $urandom_range(1000, 100);
        tol = $urandom_range(500);
        set_config(unit, tol, $urandom_range(8191, (3 * (unit + tol) > 1000) ?
                                                   3 * (unit + tol) : 1000));
        queue_random_intervals(150, 5);
        wait_idle();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rfpwc_pkg.sv
hw/rtl/rfpwc_front.sv
hw/rtl/rfpwc_queue.sv
hw/rtl/rfpwc_back.sv
hw/rtl/rf_pulse_width_code_receiver.sv
hw/rtl/rfpwc_checker.sv
tb/rf_pulse_width_code_receiver_test.sv
